>>> design/sas_pkg.sv
// Package for the stick angle slider: constants, sequencer states, shared types.
// Used by all modules in design/.
package sas_pkg;

  localparam int REGIONS_DEF = 2;
  localparam logic [16:0] FULL = 17'd65535;
  localparam logic [16:0] HALF = 17'd32768;
  localparam logic [16:0] DZ_MIN_W = 17'd655;
  localparam logic [16:0] DET_MAX = 17'd64881;
  localparam logic [16:0] DHI_MIN = 17'd6554;
  localparam logic signed [17:0] WRAP = 18'sd58982;

  localparam logic [2:0] REG_SPANS = 3'd0;
  localparam logic [2:0] REG_DETS = 3'd1;
  localparam logic [2:0] REG_DWID = 3'd2;
  localparam logic [2:0] REG_FLAGS = 3'd3;
  localparam logic [2:0] REG_DZ = 3'd4;
  localparam logic [2:0] REG_RSPD = 3'd5;
  localparam logic [2:0] REG_FSPD = 3'd6;
  localparam logic [2:0] REG_GAP = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP, ST_MUL, ST_UPD, ST_CLAMP, ST_SHAPE, ST_DIVW, ST_SHOUT, ST_OUT
  } state_t;

  // divider handshake
  typedef struct packed {
    logic        start;
    logic [33:0] num;
    logic [17:0] den;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic [33:0] quo;
  } div_rsp_t;

endpackage

>>> design/stick_angle_slider.sv
// Stick angle slider top level: registers, sequencer, shared divider.
// Depends on sas_pkg and sas_div.
//
// From one accepted beat to the next, a sample with no region update passes
// through PREP and OUT; a relative or absolute update adds MUL, UPD, CLAMP and
// SHAPE, and an absolute one waits in UPD for its target from the shared
// 34-step divider; a detent deadzone reshape that needs a division waits in
// DIVW or SHOUT for it. in_tready is high while the sequencer is idle; a
// result still waiting in the output register holds the sequencer at its
// last step. in_tdata: angle[15:0], magnitude[31:16], delta_time[47:32],
// unlock_detent[48]. out_tdata: slider_value[15:0], value_written[16],
// active_region[18:17], vibrate_strong[19], vibrate_weak[20].
module stick_angle_slider #(
  parameter int REGIONS = sas_pkg::REGIONS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // angle, magnitude, delta_time, unlock_detent
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // slider_value, value_written, active_region, strong, weak
);
  localparam logic [1:0] NONE = 2'd2;

  logic [63:0] spans_r, dets_r;
  logic [31:0] dwid_r;
  logic [5:0]  flags_r;
  logic [15:0] dz_r, rspd_r, fspd_r, gap_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spans_r <= '0; dets_r <= '0; dwid_r <= '0; flags_r <= '0;
      dz_r <= 16'd6554; rspd_r <= 16'd256; fspd_r <= 16'd256; gap_r <= 16'd100;
    end else if (cfg_we) begin
      case (cfg_index)
        sas_pkg::REG_SPANS: spans_r <= cfg_data;
        sas_pkg::REG_DETS:  dets_r <= cfg_data;
        sas_pkg::REG_DWID:  dwid_r <= cfg_data[31:0];
        sas_pkg::REG_FLAGS: flags_r <= cfg_data[5:0];
        sas_pkg::REG_DZ:    dz_r <= cfg_data[15:0];
        sas_pkg::REG_RSPD:  rspd_r <= cfg_data[15:0];
        sas_pkg::REG_FSPD:  fspd_r <= cfg_data[15:0];
        sas_pkg::REG_GAP:   gap_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  sas_pkg::state_t st_r, st_nxt;
  logic [1:0]  act_r, act_nxt;
  logic        inv_r, inv_nxt, unl_r, unl_nxt;
  logic signed [15:0] pang_r, pang_nxt;
  logic [15:0] val_r [REGIONS];
  logic [15:0] val_wd;
  logic        val_we;
  logic signed [15:0] ang_r, ang_nxt;
  logic [15:0] mag_r, mag_nxt, dt_r, dt_nxt;
  logic        ul_r, ul_nxt;
  logic signed [34:0] acc_r, acc_nxt;   // new value / product work reg
  logic [16:0] tgt_r, tgt_nxt;
  logic        strong_r, strong_nxt, weak_r, weak_nxt;
  logic        wr_r, wr_nxt;
  logic        ovalid_r, ovalid_nxt;
  logic [20:0] odata_r, odata_nxt;
  sas_pkg::div_req_t dreq;
  sas_pkg::div_rsp_t drsp;

  sas_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  // zero-extend a 17-bit value into the signed work width
  function automatic logic signed [34:0] sx35(logic [16:0] v);
    return $signed({18'd0, v});
  endfunction

  // active-region parameters
  logic ai;
  logic signed [15:0] from_a, to_a;
  logic [16:0] dhi, dlo, dw, prev, maxv, minv;
  logic rel, invm;
  always_comb begin
    ai = (REGIONS > 1) ? act_r[0] : 1'b0;
    from_a = spans_r[32*ai +: 16];
    to_a = spans_r[32*ai+16 +: 16];
    dhi = {1'b0, dets_r[32*ai +: 16]};
    dlo = {1'b0, dets_r[32*ai+16 +: 16]};
    dw = {1'b0, dwid_r[16*ai +: 16]};
    rel = flags_r[3*ai+1];
    invm = flags_r[3*ai+2];
    prev = {1'b0, val_r[ai]};
    maxv = (unl_r || dw > sas_pkg::DZ_MIN_W) ? sas_pkg::FULL
         : ((dhi < sas_pkg::DHI_MIN) ? sas_pkg::FULL : dhi);
    minv = unl_r ? 17'd0 : dlo;
  end

  logic signed [17:0] d_ang;
  logic signed [17:0] span;
  logic signed [15:0] aeff;
  logic signed [34:0] nv, delta, md;
  logic [17:0] twod, twov;
  logic signed [18:0] band_lo;   // 2*detent - width, may go negative
  logic [1:0]  pick;

  always_comb begin
    st_nxt = st_r; act_nxt = act_r; inv_nxt = inv_r; unl_nxt = unl_r;
    pang_nxt = pang_r; ang_nxt = ang_r; mag_nxt = mag_r; dt_nxt = dt_r; ul_nxt = ul_r;
    acc_nxt = acc_r; tgt_nxt = tgt_r; strong_nxt = strong_r; weak_nxt = weak_r;
    ovalid_nxt = ovalid_r; odata_nxt = odata_r;
    dreq = '0; val_we = 1'b0; val_wd = acc_r[15:0];
    in_tready = (st_r == sas_pkg::ST_IDLE);
    d_ang = '0; span = '0; aeff = ang_r; nv = '0; delta = '0; md = '0;
    twod = {dhi, 1'b0}; twov = {acc_r[16:0], 1'b0};
    band_lo = $signed({1'b0, twod}) - $signed({1'b0, 18'(dw)});
    pick = NONE;
    if (ovalid_r && out_tready) ovalid_nxt = 1'b0;
    case (st_r)
      sas_pkg::ST_IDLE: begin
        if (in_tvalid && in_tready) begin
          ang_nxt = in_tdata[15:0]; mag_nxt = in_tdata[31:16];
          dt_nxt = in_tdata[47:32]; ul_nxt = in_tdata[48];
          strong_nxt = 1'b0; weak_nxt = 1'b0;
          st_nxt = sas_pkg::ST_PREP;
        end
      end
      // flags, deadzone, region search
      sas_pkg::ST_PREP: begin
        unl_nxt = unl_r | ul_r;
        inv_nxt = inv_r | (dt_r > gap_r);
        st_nxt = sas_pkg::ST_OUT;
        tgt_nxt = '0;
        acc_nxt = '0;
        if (mag_r > dz_r) begin
          if (!inv_nxt) begin
            pick = act_r;
            if (act_r >= REGIONS[1:0]) begin
              pick = NONE;
              for (int r = REGIONS - 1; r >= 0; r--) begin
                if (flags_r[3*r] && $signed(spans_r[32*r +: 16]) < ang_r
                    && ang_r < $signed(spans_r[32*r+16 +: 16])) pick = r[1:0];
              end
            end
            act_nxt = pick;
            if (pick < REGIONS[1:0]) st_nxt = sas_pkg::ST_MUL;
          end
        end else begin
          act_nxt = NONE; unl_nxt = 1'b0; inv_nxt = 1'b0;
        end
        if (st_nxt == sas_pkg::ST_OUT) pang_nxt = ang_r;
      end
      // relative product or absolute target division
      sas_pkg::ST_MUL: begin
        if (rel) begin
          d_ang = 18'(ang_r) - 18'(pang_r);
          if (d_ang > sas_pkg::WRAP || d_ang < -sas_pkg::WRAP)
            d_ang = (d_ang < 0) ? d_ang + 18'sd65536 : d_ang - 18'sd65536;
          if (invm) d_ang = -d_ang;
          acc_nxt = 35'(d_ang) * $signed({19'd0, rspd_r}) + 35'sd64;
          st_nxt = sas_pkg::ST_UPD;
        end else begin
          aeff = ang_r;
          if (ang_r < from_a || to_a < ang_r)
            aeff = (((invm ? sas_pkg::FULL - prev : prev) < sas_pkg::HALF)) ? from_a : to_a;
          span = 18'(to_a) - 18'(from_a);
          acc_nxt = 35'(aeff) - 35'(from_a);
          if (span > 0) begin
            dreq.start = 1'b1;
            dreq.num = {acc_nxt[17:0], 16'd0};
            dreq.den = span;
          end
          st_nxt = sas_pkg::ST_UPD;
        end
      end
      // new value
      sas_pkg::ST_UPD: begin
        if (rel) begin
          nv = sx35(prev) + (acc_r >>> 7);
          if (prev < maxv && nv > sx35(maxv)) strong_nxt = 1'b1;
          if ((prev < sas_pkg::HALF) != (nv < sx35(sas_pkg::HALF))) weak_nxt = 1'b1;
          if (prev > minv && nv < sx35(minv)) strong_nxt = 1'b1;
          acc_nxt = nv;
          st_nxt = sas_pkg::ST_CLAMP;
        end else if (!drsp.busy) begin
          span = 18'(to_a) - 18'(from_a);
          tgt_nxt = (span > 0) ? ((drsp.quo > 34'(sas_pkg::FULL)) ? sas_pkg::FULL
                                   : drsp.quo[16:0]) : 17'd0;
          if (invm) tgt_nxt = sas_pkg::FULL - tgt_nxt;
          if ((prev < dhi) != (tgt_nxt < dhi)) strong_nxt = 1'b1;
          md = $signed({19'd0, dt_r}) * $signed({19'd0, fspd_r});
          delta = sx35(tgt_nxt) - sx35(prev);
          if (((delta < 0) ? -delta : delta) < md) acc_nxt = sx35(tgt_nxt);
          else acc_nxt = sx35(prev) + ((delta < 0) ? -md : md);
          st_nxt = sas_pkg::ST_CLAMP;
        end
      end
      sas_pkg::ST_CLAMP: begin
        nv = acc_r;
        if (nv < sx35(minv)) nv = sx35(minv);
        if (nv > sx35(maxv)) nv = sx35(maxv);
        acc_nxt = nv;
        val_we = 1'b1; val_wd = nv[15:0];
        st_nxt = sas_pkg::ST_SHAPE;
      end
      // detent deadzone reshape
      sas_pkg::ST_SHAPE: begin
        tgt_nxt = acc_r[16:0];
        if (dw <= sas_pkg::DZ_MIN_W || dhi >= sas_pkg::DET_MAX) begin
          st_nxt = sas_pkg::ST_OUT;
        end else if (band_lo <= $signed({1'b0, twov}) && twov <= twod + 18'(dw)) begin
          tgt_nxt = dhi; st_nxt = sas_pkg::ST_OUT;
        end else if ($signed({1'b0, twov}) < band_lo) begin
          dreq.start = 1'b1;
          dreq.num = 34'(twod) * 34'(acc_r[16:0]);
          dreq.den = band_lo[17:0];
          st_nxt = sas_pkg::ST_DIVW;
        end else begin
          dreq.start = 1'b1;
          dreq.num = 34'(sas_pkg::FULL - dhi) * 34'(twov - twod - 18'(dw));
          dreq.den = {sas_pkg::FULL, 1'b0} - twod - 18'(dw);
          st_nxt = sas_pkg::ST_SHOUT;
        end
      end
      sas_pkg::ST_DIVW: begin
        if (!drsp.busy) begin
          tgt_nxt = drsp.quo[16:0]; st_nxt = sas_pkg::ST_OUT;
        end
      end
      sas_pkg::ST_SHOUT: begin
        if (!drsp.busy) begin
          tgt_nxt = drsp.quo[16:0] + dhi; st_nxt = sas_pkg::ST_OUT;
        end
      end
      // wait for a free result register, then load the beat
      sas_pkg::ST_OUT: begin
        if (!ovalid_nxt) begin
          odata_nxt = {weak_r, strong_r, act_r, wr_r,
                       (tgt_r > sas_pkg::FULL) ? 16'hFFFF : tgt_r[15:0]};
          ovalid_nxt = 1'b1;
          pang_nxt = ang_r;
          st_nxt = sas_pkg::ST_IDLE;
        end
      end
      default: st_nxt = sas_pkg::ST_IDLE;
    endcase
  end

  // written flag: set whenever the value path ran
  always_comb begin
    wr_nxt = wr_r;
    if (st_r == sas_pkg::ST_PREP) wr_nxt = 1'b0;
    if (val_we) wr_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= sas_pkg::ST_IDLE; act_r <= NONE; inv_r <= 1'b0; unl_r <= 1'b0;
      pang_r <= '0; ovalid_r <= 1'b0; wr_r <= 1'b0;
      for (int r = 0; r < REGIONS; r++) val_r[r] <= '0;
    end else begin
      st_r <= st_nxt; act_r <= act_nxt; inv_r <= inv_nxt; unl_r <= unl_nxt;
      pang_r <= pang_nxt; ovalid_r <= ovalid_nxt;
      wr_r <= wr_nxt;
      if (val_we) val_r[ai] <= val_wd;
    end
    ang_r <= ang_nxt; mag_r <= mag_nxt; dt_r <= dt_nxt; ul_r <= ul_nxt;
    acc_r <= acc_nxt; tgt_r <= tgt_nxt; strong_r <= strong_nxt; weak_r <= weak_nxt;
    odata_r <= odata_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata = {3'd0, odata_r};
endmodule

>>> design/sas_div.sv
// Restoring divider, one quotient bit a cycle, unsigned.
// Depends on sas_pkg.
module sas_div (
  input  logic              clk,
  input  logic              rst_n,
  input  sas_pkg::div_req_t req,
  output sas_pkg::div_rsp_t rsp
);
  logic [33:0] q_r, q_nxt;
  logic [17:0] d_r, d_nxt;
  logic [17:0] rem_r, rem_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [18:0] sh;

  // shift-subtract step
  always_comb begin
    q_nxt = q_r; d_nxt = d_r; rem_nxt = rem_r; cnt_nxt = cnt_r;
    sh = {rem_r, q_r[33]};
    if (req.start) begin
      q_nxt = req.num; d_nxt = req.den; rem_nxt = '0; cnt_nxt = 6'd34;
    end else if (cnt_r != 6'd0) begin
      cnt_nxt = cnt_r - 6'd1;
      if (sh >= {1'b0, d_r}) begin
        rem_nxt = 18'(sh - {1'b0, d_r}); q_nxt = {q_r[32:0], 1'b1};
      end else begin
        rem_nxt = sh[17:0]; q_nxt = {q_r[32:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else cnt_r <= cnt_nxt;
    q_r <= q_nxt; d_r <= d_nxt; rem_r <= rem_nxt;
  end

  assign rsp.busy = (cnt_r != 6'd0) || req.start;
  assign rsp.quo = q_r;
endmodule
